// File: design/per_channel_requant_mul_add_defines.svh
// ---------------------------------------------------------------------------
// per_channel_requant_mul_add_defines.svh
// Assertion macros used by the requantizer RTL.
// ---------------------------------------------------------------------------
// Both macros expect signals named clk and rst_n in the module that uses them.
`ifndef PER_CHANNEL_REQUANT_MUL_ADD_DEFINES_SVH
`define PER_CHANNEL_REQUANT_MUL_ADD_DEFINES_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset
`define PCRQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pcrq assertion failed");

// Condition that must hold in the cycle after a trigger
`define PCRQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcrq assertion failed");

`else

`define PCRQ_ASSERT(lbl, prop)
`define PCRQ_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: design/pcrq_pkg.sv
// ---------------------------------------------------------------------------
// pcrq_pkg
// Constants, types and the round/saturate function of the requantizer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pcrq_pkg;

  // Channel store geometry
  localparam int CHANNELS = 64;
  localparam int CH_W     = $clog2(CHANNELS);
  localparam int CNT_W    = CH_W + 1;

  // Datapath widths
  localparam int WORD_W = 32;
  localparam int SMP_W  = 9;                 // sample or x, sign- or zero-extended
  localparam int PROD_W = SMP_W + WORD_W;
  localparam int ACC_W  = 48;
  localparam int SH_W   = 6;
  localparam int COEF_W = 3 * WORD_W;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // APB address decode
  localparam int ADDR_W = 5;

  // Request codes
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // Register indexes
  typedef enum logic [2:0] {
    REG_SIGNED_MODE   = 3'd0,
    REG_RELU_ENABLE   = 3'd1,
    REG_PRODUCT_SHIFT = 3'd2,
    REG_OUTPUT_SHIFT  = 3'd3,
    REG_OUTPUT_SCALE  = 3'd4,
    REG_CHANNEL_COUNT = 3'd5
  } reg_idx_t;

  // Saturation bounds
  localparam logic signed [SMP_W-1:0] SAT_MIN_S = -9'sd128;
  localparam logic signed [SMP_W-1:0] SAT_MAX_S = 9'sd127;
  localparam logic signed [SMP_W-1:0] SAT_MAX_U = 9'sd255;

  // One queued word: a coefficient load or a classified sample
  typedef struct packed {
    logic              is_load;
    logic [CH_W-1:0]   ch;
    logic              last;
    logic [7:0]        sample;
    logic [WORD_W-1:0] scale;
    logic [WORD_W-1:0] off1;
    logic [WORD_W-1:0] off2;
  } qentry_t;

  // Configuration seen by the back end
  typedef struct packed {
    logic                     signed_mode;
    logic                     relu_enable;
    logic [SH_W-1:0]          product_shift;
    logic [SH_W-1:0]          output_shift;
    logic signed [WORD_W-1:0] output_scale;
  } bcfg_t;

  // Shift right rounding half away from zero, then saturate
  // to int8 or uint8. Operates on sign and magnitude.
  function automatic logic signed [SMP_W-1:0] round_sat(
    input logic [ACC_W-1:0] mag,
    input logic             neg,
    input logic [SH_W-1:0]  sh,
    input logic             sgn
  );
    logic [ACC_W:0]            rnd;
    logic [ACC_W:0]            sum;
    logic [ACC_W:0]            q;
    logic                      big;
    logic signed [SMP_W-1:0]   hi;
    logic signed [SMP_W-1:0]   r;
    rnd = '0;
    sum = '0;
    if (sh == '0) begin
      q = {1'b0, mag};
    end else if (sh > SH_W'(ACC_W)) begin
      q = '0;
    end else begin
      rnd = {{ACC_W{1'b0}}, 1'b1} << (sh - SH_W'(1));
      sum = {1'b0, mag} + rnd;
      q   = sum >> sh;
    end
    big = |q[ACC_W:8];
    hi  = sgn ? SAT_MAX_S : SAT_MAX_U;
    if (neg) begin
      if (!sgn) begin
        r = '0;
      end else if (big || (q[7:0] >= 8'd128)) begin
        r = SAT_MIN_S;
      end else begin
        r = -$signed({1'b0, q[7:0]});
      end
    end else begin
      if (big || ($signed({1'b0, q[7:0]}) > hi)) begin
        r = hi;
      end else begin
        r = $signed({1'b0, q[7:0]});
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/per_channel_requant_mul_add.sv
// Throughput: one word (load or sample) per cycle unless the output stalls,
// set by the single issue stage that pops the 4-entry queue and reads the
// coefficient RAM. Loads produce no result. Output backpressure freezes the
// whole pipeline.
// Reset (rst_n, synchronous): position, queue and valids clear, registers
// take their reset values; the coefficient RAM is not cleared.
// ---------------------------------------------------------------------------
// per_channel_requant_mul_add
// Per-channel two-stage requantizing multiply-add with APB register port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module per_channel_requant_mul_add
  import pcrq_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  // APB configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [WORD_W-1:0]   pwdata,
  output logic      [WORD_W-1:0]   prdata,
  output logic                     pready,
  // input channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_req_type,
  input  wire logic [CH_W-1:0]     in_load_channel,
  input  wire logic [WORD_W-1:0]   in_scale_word,
  input  wire logic [WORD_W-1:0]   in_first_offset_word,
  input  wire logic [WORD_W-1:0]   in_second_offset_word,
  input  wire logic [7:0]          in_sample,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [7:0]               out_result_byte,
  output logic [CH_W-1:0]          out_result_channel,
  output logic                     out_row_last
);

  // Configuration registers
  logic                     signed_mode_r;
  logic                     signed_mode_nxt;
  logic                     relu_enable_r;
  logic                     relu_enable_nxt;
  logic [SH_W-1:0]          product_shift_r;
  logic [SH_W-1:0]          product_shift_nxt;
  logic [SH_W-1:0]          output_shift_r;
  logic [SH_W-1:0]          output_shift_nxt;
  logic signed [WORD_W-1:0] output_scale_r;
  logic signed [WORD_W-1:0] output_scale_nxt;
  logic [CNT_W-1:0]         channel_count_r;
  logic [CNT_W-1:0]         channel_count_nxt;

  logic     wr_en;
  reg_idx_t reg_idx;
  bcfg_t    bcfg;

  // Front/queue/back links
  logic    q_full;
  logic    q_push;
  qentry_t q_in;
  logic    q_pop;
  qentry_t q_out;
  logic    q_nonempty;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[4:2]);

  // Register write decode
  always_comb begin
    signed_mode_nxt   = signed_mode_r;
    relu_enable_nxt   = relu_enable_r;
    product_shift_nxt = product_shift_r;
    output_shift_nxt  = output_shift_r;
    output_scale_nxt  = output_scale_r;
    channel_count_nxt = channel_count_r;
    if (wr_en) begin
      case (reg_idx)
        REG_SIGNED_MODE:   signed_mode_nxt   = pwdata[0];
        REG_RELU_ENABLE:   relu_enable_nxt   = pwdata[0];
        REG_PRODUCT_SHIFT: product_shift_nxt = pwdata[SH_W-1:0];
        REG_OUTPUT_SHIFT:  output_shift_nxt  = pwdata[SH_W-1:0];
        REG_OUTPUT_SCALE:  output_scale_nxt  = $signed(pwdata);
        REG_CHANNEL_COUNT: channel_count_nxt = pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_mode_r   <= 1'b1;
      relu_enable_r   <= 1'b0;
      product_shift_r <= SH_W'(15);
      output_shift_r  <= SH_W'(15);
      output_scale_r  <= '0;
      channel_count_r <= CNT_W'(CHANNELS);
    end else begin
      signed_mode_r   <= signed_mode_nxt;
      relu_enable_r   <= relu_enable_nxt;
      product_shift_r <= product_shift_nxt;
      output_shift_r  <= output_shift_nxt;
      output_scale_r  <= output_scale_nxt;
      channel_count_r <= channel_count_nxt;
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      REG_SIGNED_MODE:   prdata = {{(WORD_W-1){1'b0}}, signed_mode_r};
      REG_RELU_ENABLE:   prdata = {{(WORD_W-1){1'b0}}, relu_enable_r};
      REG_PRODUCT_SHIFT: prdata = {{(WORD_W-SH_W){1'b0}}, product_shift_r};
      REG_OUTPUT_SHIFT:  prdata = {{(WORD_W-SH_W){1'b0}}, output_shift_r};
      REG_OUTPUT_SCALE:  prdata = output_scale_r;
      REG_CHANNEL_COUNT: prdata = {{(WORD_W-CNT_W){1'b0}}, channel_count_r};
      default:           prdata = '0;
    endcase
  end

  always_comb begin
    bcfg.signed_mode   = signed_mode_r;
    bcfg.relu_enable   = relu_enable_r;
    bcfg.product_shift = product_shift_r;
    bcfg.output_shift  = output_shift_r;
    bcfg.output_scale  = output_scale_r;
  end

  pcrq_front u_front (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .channel_count         (channel_count_r),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_req_type           (in_req_type),
    .in_load_channel       (in_load_channel),
    .in_scale_word         (in_scale_word),
    .in_first_offset_word  (in_first_offset_word),
    .in_second_offset_word (in_second_offset_word),
    .in_sample             (in_sample),
    .q_full                (q_full),
    .q_push                (q_push),
    .q_data                (q_in)
  );

  pcrq_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .nonempty  (q_nonempty)
  );

  pcrq_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (bcfg),
    .q_nonempty         (q_nonempty),
    .q_data             (q_out),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_byte    (out_result_byte),
    .out_result_channel (out_result_channel),
    .out_row_last       (out_row_last)
  );

endmodule

`default_nettype wire

// File: design/pcrq_ram.sv
// ---------------------------------------------------------------------------
// pcrq_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcrq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// File: design/pcrq_front.sv
// ---------------------------------------------------------------------------
// pcrq_front
// Accepts input words, classifies loads and samples, tracks channel position.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcrq_front
  import pcrq_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [CNT_W-1:0]         channel_count,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     in_req_type,
  input  wire logic [CH_W-1:0]          in_load_channel,
  input  wire logic [WORD_W-1:0]        in_scale_word,
  input  wire logic [WORD_W-1:0]        in_first_offset_word,
  input  wire logic [WORD_W-1:0]        in_second_offset_word,
  input  wire logic [7:0]               in_sample,
  input  wire logic                     q_full,
  output logic                          q_push,
  output qentry_t                       q_data
);

  logic [CH_W-1:0]  pos_r;
  logic [CH_W-1:0]  pos_nxt;
  logic [CNT_W-1:0] count_eff;
  logic             is_load;
  logic             last;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign is_load  = (in_req_type == REQ_LOAD);

  // Effective row length: zero or oversize counts mean the full store
  always_comb begin
    if ((channel_count == '0) || (channel_count > CNT_W'(CHANNELS))) begin
      count_eff = CNT_W'(CHANNELS);
    end else begin
      count_eff = channel_count;
    end
  end

  // Last in row, also when the count shrank below the position
  assign last = (({1'b0, pos_r} + CNT_W'(1)) >= count_eff);

  // Queue word
  always_comb begin
    q_data.is_load = is_load;
    q_data.ch      = is_load ? in_load_channel : pos_r;
    q_data.last    = last;
    q_data.sample  = in_sample;
    q_data.scale   = in_scale_word;
    q_data.off1    = in_first_offset_word;
    q_data.off2    = in_second_offset_word;
  end

  // Position steps on each accepted sample
  always_comb begin
    pos_nxt = pos_r;
    if (q_push && !is_load) begin
      pos_nxt = last ? '0 : pos_r + CH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/pcrq_fifo.sv
// ---------------------------------------------------------------------------
// pcrq_fifo
// Short queue that decouples the front end from the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "per_channel_requant_mul_add_defines.svh"

module pcrq_fifo
  import pcrq_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire qentry_t push_data,
  output logic         full,
  input  wire logic    pop,
  output qentry_t      pop_data,
  output logic         nonempty
);

  qentry_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r;
  logic [QPTR_W:0]   cnt_nxt;

  assign full     = (cnt_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign nonempty = (cnt_r != '0);
  assign pop_data = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (QPTR_W + 1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Checks
  `PCRQ_ASSERT(a_no_pop_empty, !pop || (cnt_r != '0))
  `PCRQ_ASSERT(a_no_push_full, !push || !full || pop)
  `PCRQ_ASSERT(a_ptr_gap, QPTR_W'(wr_ptr_r - rd_ptr_r) == cnt_r[QPTR_W-1:0])
  `PCRQ_ASSERT_NEXT(a_cnt_inc, push && !pop, cnt_r == $past(cnt_r) + (QPTR_W + 1)'(1))

endmodule

`default_nettype wire

// File: design/pcrq_back.sv
// ---------------------------------------------------------------------------
// pcrq_back
// Coefficient store and the multiply/round/saturate pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcrq_back
  import pcrq_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire bcfg_t        cfg,
  input  wire logic         q_nonempty,
  input  wire qentry_t      q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [7:0]        out_result_byte,
  output logic [CH_W-1:0]   out_result_channel,
  output logic              out_row_last
);

  // Pipeline control
  logic       adv;
  logic [8:1] v_r;
  logic [8:1] v_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  // Coefficient store port
  logic              ram_we;
  logic              ram_re;
  logic [COEF_W-1:0] ram_wdata;
  logic [COEF_W-1:0] ram_rdata;

  // Per-stage tags
  logic [CH_W-1:0] pos_r  [1:8];
  logic            last_r [1:8];

  // Datapath registers
  logic signed [SMP_W-1:0]  smp_r;
  logic signed [SMP_W-1:0]  smp_nxt;
  logic signed [PROD_W-1:0] prod1_r;
  logic signed [PROD_W-1:0] prod1_nxt;
  logic signed [WORD_W-1:0] off1_r;
  logic signed [WORD_W-1:0] off2_r [2:6];
  logic signed [ACC_W-1:0]  acc1_r;
  logic signed [ACC_W-1:0]  acc1_nxt;
  logic                     neg1_r;
  logic [ACC_W-1:0]         mag1_r;
  logic [ACC_W-1:0]         mag1_nxt;
  logic signed [SMP_W-1:0]  x_r;
  logic signed [SMP_W-1:0]  x_nxt;
  logic signed [PROD_W-1:0] prod2_r;
  logic signed [PROD_W-1:0] prod2_nxt;
  logic signed [ACC_W-1:0]  acc2_r;
  logic signed [ACC_W-1:0]  acc2_nxt;
  logic                     neg2_r;
  logic [ACC_W-1:0]         mag2_r;
  logic [ACC_W-1:0]         mag2_nxt;
  logic signed [SMP_W-1:0]  y_raw;
  logic [7:0]               y_r;
  logic [7:0]               y_nxt;

  // Whole pipeline moves unless a finished word is held at the output
  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && q_nonempty;

  // Loads write the store in queue order, samples read it
  assign ram_we    = q_pop && q_data.is_load;
  assign ram_re    = q_pop && !q_data.is_load;
  assign ram_wdata = {q_data.scale, q_data.off1, q_data.off2};

  pcrq_ram #(
    .WIDTH (COEF_W),
    .DEPTH (CHANNELS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_data.ch),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (q_data.ch),
    .rdata (ram_rdata)
  );

  // Valid tracking
  always_comb begin
    v_nxt         = adv ? {v_r[7:1], ram_re} : v_r;
    out_valid_nxt = adv ? v_r[8] : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v_r         <= v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Stage arithmetic
  always_comb begin
    // sample read as int8 or uint8
    smp_nxt   = cfg.signed_mode ? $signed({q_data.sample[7], q_data.sample})
                                : $signed({1'b0, q_data.sample});
    // first product, store data is ready this stage
    prod1_nxt = smp_r * $signed(ram_rdata[3*WORD_W-1:2*WORD_W]);
    acc1_nxt  = ACC_W'(off1_r) + ACC_W'(prod1_r);
    mag1_nxt  = acc1_r[ACC_W-1] ? ACC_W'(-acc1_r) : ACC_W'(acc1_r);
    x_nxt     = round_sat(mag1_r, neg1_r, cfg.product_shift, cfg.signed_mode);
    // second product
    prod2_nxt = x_r * cfg.output_scale;
    acc2_nxt  = ACC_W'(off2_r[6]) + ACC_W'(prod2_r);
    mag2_nxt  = acc2_r[ACC_W-1] ? ACC_W'(-acc2_r) : ACC_W'(acc2_r);
    y_raw     = round_sat(mag2_r, neg2_r, cfg.output_shift, cfg.signed_mode);
    // optional ReLU
    if (cfg.relu_enable && y_raw[SMP_W-1]) begin
      y_nxt = '0;
    end else begin
      y_nxt = y_raw[7:0];
    end
  end

  // Payload registers, frozen with the pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      smp_r     <= smp_nxt;
      pos_r[1]  <= q_data.ch;
      last_r[1] <= q_data.last;
      for (int i = 2; i <= 8; i++) begin
        pos_r[i]  <= pos_r[i-1];
        last_r[i] <= last_r[i-1];
      end
      prod1_r   <= prod1_nxt;
      off1_r    <= $signed(ram_rdata[2*WORD_W-1:WORD_W]);
      off2_r[2] <= $signed(ram_rdata[WORD_W-1:0]);
      for (int i = 3; i <= 6; i++) begin
        off2_r[i] <= off2_r[i-1];
      end
      acc1_r  <= acc1_nxt;
      neg1_r  <= acc1_r[ACC_W-1];
      mag1_r  <= mag1_nxt;
      x_r     <= x_nxt;
      prod2_r <= prod2_nxt;
      acc2_r  <= acc2_nxt;
      neg2_r  <= acc2_r[ACC_W-1];
      mag2_r  <= mag2_nxt;
      y_r     <= y_nxt;
      out_result_channel <= pos_r[8];
      out_row_last       <= last_r[8];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_byte = y_r;

endmodule

`default_nettype wire
